// File: hw/rtl/ims_pkg.sv
// Shared constants, control structs and helper functions of the Ising sampler.
package ims_pkg;

  localparam int SITES_DEF       = 64;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int EXP_DEPTH_DEF   = 256;

  localparam int CMD_W     = 3;
  localparam int ADDR_W    = 12;
  localparam int CPL_W     = 16;
  localparam int RND_W     = 16;
  localparam int SPIN_W    = 64;
  localparam int ACT_W     = 7;
  localparam int CNT_OUT_W = 32;
  localparam int FIELD_W   = 24;
  localparam int EXP_W     = 16;
  localparam int D_SPAN    = 65536;

  localparam logic [63:0] CNT_OUT_MAX = 64'hFFFF_FFFF;
  localparam logic [63:0] INV_E_Q32   = 64'd1580030169;

  localparam logic [CMD_W-1:0] CMD_WR_CPL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_SPIN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

  typedef struct packed {
    logic rd;
    logic wr;
  } fld_ctrl_t;

  typedef struct packed {
    logic pair_rd;
    logic pair_wr;
    logic hist_rd;
    logic hist_wr;
    logic hist_clr;
  } cnt_ctrl_t;

  // clamp to the signed field range
  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [FIELD_W+1:0] v);
    logic signed [FIELD_W+1:0] hi;
    logic signed [FIELD_W+1:0] lo;
    hi = (FIELD_W+2)'(8388607);
    lo = -(FIELD_W+2)'(8388608);
    if (v > hi) return hi[FIELD_W-1:0];
    if (v < lo) return lo[FIELD_W-1:0];
    return v[FIELD_W-1:0];
  endfunction

  // exp(-(whole + frac/2^32)) in Q0.16, elaboration use only
  function automatic logic [EXP_W-1:0] exp_value(input logic [63:0] frac,
                                                 input logic [63:0] whole);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] r;
    term = 64'h1_0000_0000;
    sum  = term;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    v = sum;
    for (int n = 0; n < 16; n++) begin
      if (64'(n) < whole) v = (v * INV_E_Q32 + 64'h8000_0000) >> 32;
    end
    r = (v + 64'd32768) >> 16;
    return (r > 64'd65535) ? 16'hFFFF : r[EXP_W-1:0];
  endfunction

endpackage

// File: hw/rtl/ims_if.sv
// Command and result channel interfaces of the Ising sampler.
interface ims_in_if;
  logic                               valid;
  logic                               ready;
  logic [ims_pkg::CMD_W-1:0]          command;
  logic [ims_pkg::ADDR_W-1:0]         address;
  logic signed [ims_pkg::CPL_W-1:0]   coupling_value;
  logic                               spin_value;
  logic                               typed_flag;
  logic [ims_pkg::RND_W-1:0]          random_fraction;

  modport source (output valid, command, address, coupling_value, spin_value, typed_flag,
                  random_fraction, input ready);
  modport sink (input valid, command, address, coupling_value, spin_value, typed_flag,
                random_fraction, output ready);
endinterface

interface ims_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic [ims_pkg::SPIN_W-1:0]        spin_word;
  logic [ims_pkg::ACT_W-1:0]         active_count;
  logic [ims_pkg::CNT_OUT_W-1:0]     count_value;
  logic                              bad_address;

  modport source (output valid, accepted, spin_word, active_count, count_value, bad_address,
                  input ready);
  modport sink (input valid, accepted, spin_word, active_count, count_value, bad_address,
                output ready);
endinterface

// File: hw/rtl/ims_field_store.sv
// Local field memory, one read and one write port, unwritten entries read as zero.
module ims_field_store #(
  parameter int SITES = ims_pkg::SITES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ims_pkg::fld_ctrl_t                    ctrl,
  input  logic [$clog2(SITES)-1:0]              rd_addr,
  input  logic [$clog2(SITES)-1:0]              wr_addr,
  input  logic signed [ims_pkg::FIELD_W-1:0]    wr_data,
  output logic signed [ims_pkg::FIELD_W-1:0]    q
);

  logic signed [ims_pkg::FIELD_W-1:0] mem [SITES];
  logic [SITES-1:0]                   vld_r;
  logic signed [ims_pkg::FIELD_W-1:0] q_raw_r;
  logic                               qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) mem[wr_addr] <= wr_data;
    if (ctrl.rd) begin
      q_raw_r <= mem[rd_addr];
      qv_r    <= vld_r[rd_addr];
    end
  end

  assign q = qv_r ? q_raw_r : '0;

endmodule

// File: hw/rtl/ims_count_store.sv
// Pair counter memory and activity histogram memory.
module ims_count_store #(
  parameter int SITES       = ims_pkg::SITES_DEF,
  parameter int COUNT_WIDTH = ims_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  ims_pkg::cnt_ctrl_t                            ctrl,
  input  logic [$clog2(SITES*(SITES+1)/2)-1:0]          pair_rd_addr,
  input  logic [$clog2(SITES*(SITES+1)/2)-1:0]          pair_wr_addr,
  input  logic [COUNT_WIDTH-1:0]                        pair_wd,
  input  logic [$clog2(SITES+1)-1:0]                    hist_rd_addr,
  input  logic [$clog2(SITES+1)-1:0]                    hist_wr_addr,
  input  logic [COUNT_WIDTH-1:0]                        hist_wd,
  output logic [COUNT_WIDTH-1:0]                        pair_q,
  output logic [COUNT_WIDTH-1:0]                        hist_q
);

  localparam int PAIRS  = SITES * (SITES + 1) / 2;
  localparam int HIST_N = SITES + 1;

  logic [COUNT_WIDTH-1:0] pair_mem [PAIRS];
  logic [COUNT_WIDTH-1:0] hist_mem [HIST_N];
  logic [HIST_N-1:0]      hist_vld_r;
  logic [COUNT_WIDTH-1:0] hist_raw_r;
  logic                   hist_qv_r;

  always_ff @(posedge clk) begin
    if (ctrl.pair_wr) pair_mem[pair_wr_addr] <= pair_wd;
    if (ctrl.pair_rd) pair_q <= pair_mem[pair_rd_addr];
    if (ctrl.hist_wr) hist_mem[hist_wr_addr] <= hist_wd;
    if (ctrl.hist_rd) begin
      hist_raw_r <= hist_mem[hist_rd_addr];
      hist_qv_r  <= hist_vld_r[hist_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.hist_clr) begin
      hist_vld_r <= '0;
    end else if (ctrl.hist_wr) begin
      hist_vld_r[hist_wr_addr] <= 1'b1;
    end
  end

  assign hist_q = hist_qv_r ? hist_raw_r : '0;

endmodule

// File: hw/rtl/ims_exp_rom.sv
// exp(-x) acceptance table, built at elaboration, registered read.
module ims_exp_rom #(
  parameter int EXP_TABLE_DEPTH = ims_pkg::EXP_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0]   idx,
  output logic [ims_pkg::EXP_W-1:0]            q
);

  logic [ims_pkg::EXP_W-1:0] rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] Num   = 64'(g) * 64'd16;
    localparam logic [63:0] Whole = Num / EXP_TABLE_DEPTH;
    localparam logic [63:0] Frac  = ((Num % EXP_TABLE_DEPTH) << 32) / EXP_TABLE_DEPTH;
    localparam logic [ims_pkg::EXP_W-1:0] Val = ims_pkg::exp_value(Frac, Whole);
    assign rom[g] = Val;
  end

  always_ff @(posedge clk) begin
    q <= rom[idx];
  end

endmodule

// File: hw/rtl/ising_metropolis_sampler.sv
// Metropolis sampler top level: command decoder, coupling memory, spin state.
// An accepted update makes one pass over the field memory; init builds the fields through the
// coupling memory read port; record walks the pairs of each active site, then bumps the
// histogram; clear empties the histogram and makes a pass over the pair counters.
// One word in flight at a time; the next word is taken once the result is queued.
// Reset: a pass over the pair counters zeroes them, no word taken meanwhile.
module ising_metropolis_sampler #(
  parameter int SITES           = ims_pkg::SITES_DEF,
  parameter int COUNT_WIDTH     = ims_pkg::COUNT_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = ims_pkg::EXP_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ims_in_if.sink     in_chan,
  ims_out_if.source  out_chan
);

  localparam int SW    = $clog2(SITES);
  localparam int PAIRS = SITES * (SITES + 1) / 2;
  localparam int PAW   = $clog2(PAIRS);
  localparam int HAW   = $clog2(SITES + 1);
  localparam int EAW   = $clog2(EXP_TABLE_DEPTH);
  localparam int EDW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int FW    = ims_pkg::FIELD_W;
  localparam logic [SW-1:0] LAST_SITE = SW'(SITES - 1);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DECODE  = 4'd2;
  localparam logic [3:0] ST_INIT    = 4'd3;
  localparam logic [3:0] ST_DRAIN   = 4'd4;
  localparam logic [3:0] ST_UPD_D   = 4'd5;
  localparam logic [3:0] ST_UPD_EXP = 4'd6;
  localparam logic [3:0] ST_UPD_DEC = 4'd7;
  localparam logic [3:0] ST_UPD_SWP = 4'd8;
  localparam logic [3:0] ST_REC     = 4'd9;
  localparam logic [3:0] ST_REC_HRD = 4'd10;
  localparam logic [3:0] ST_REC_HWR = 4'd11;
  localparam logic [3:0] ST_READ    = 4'd12;
  localparam logic [3:0] ST_DONE    = 4'd13;

  function automatic logic [PAW-1:0] tri_addr(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    int unsigned   l;
    int unsigned   h;
    int unsigned   base;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    l    = 32'(lo);
    h    = 32'(hi);
    base = 32'(SITES - 1) + l * 32'(SITES - 2) - ((l * (l - 32'd1)) >> 1);
    return (a == b) ? PAW'(l) : PAW'(base + h);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // item registers
  logic [ims_pkg::CMD_W-1:0]        cmd_r;
  logic [ims_pkg::ADDR_W-1:0]       addr_r;
  logic signed [ims_pkg::CPL_W-1:0] cval_r;
  logic                             sval_r;
  logic                             tflag_r;
  logic [ims_pkg::RND_W-1:0]        rnd_r;

  logic [3:0]                state_r, state_nxt;
  logic [SITES-1:0]          spins_r, spins_nxt;
  logic [SITES-1:0]          typed_r, typed_nxt;
  logic [HAW-1:0]            last_active_r, last_active_nxt;
  logic [SW-1:0]             i_r, i_nxt;
  logic [SW-1:0]             j_r, j_nxt;
  logic [PAW-1:0]            clr_r, clr_nxt;
  logic                      clr_cmd_r, clr_cmd_nxt;
  logic                      acc_pend_r, acc_pend_nxt;
  logic                      bad_pend_r, bad_pend_nxt;
  logic [ims_pkg::CNT_OUT_W-1:0] cnt_pend_r, cnt_pend_nxt;
  logic                      up_r, up_nxt;
  logic                      d_le0_r, d_le0_nxt;
  logic                      d_big_r, d_big_nxt;
  logic [EAW-1:0]            eidx_r, eidx_nxt;
  logic [HAW-1:0]            act_r, act_nxt;
  logic                      sel_hist_r, sel_hist_nxt;
  logic signed [FW+1:0]      acc_sum_r, acc_sum_nxt;

  logic                      p1_v_r, p1_v_nxt;
  logic                      p1_add_r, p1_add_nxt;
  logic                      p1_first_r, p1_first_nxt;
  logic                      p1_last_r, p1_last_nxt;
  logic [SW-1:0]             p1_site_r, p1_site_nxt;
  logic                      p2_v_r, p2_v_nxt;
  logic                      p2_skip_r, p2_skip_nxt;
  logic [SW-1:0]             p2_site_r, p2_site_nxt;
  logic                      p3_v_r, p3_v_nxt;
  logic [PAW-1:0]            p3_addr_r, p3_addr_nxt;

  logic                      out_valid_r;
  logic                      out_acc_r;
  logic [ims_pkg::SPIN_W-1:0]    out_spins_r;
  logic [ims_pkg::ACT_W-1:0]     out_act_r;
  logic [ims_pkg::CNT_OUT_W-1:0] out_cnt_r;
  logic                      out_bad_r;
  logic                      out_load;

  logic                      in_fire;
  logic [SW-1:0]             k;
  logic                      upd_ok;
  logic                      rec_cond;
  logic signed [FW:0]        dval;
  logic [16+EDW-1:0]         eprod;
  logic [COUNT_WIDTH-1:0]    rd_cnt;

  // coupling memory
  logic signed [ims_pkg::CPL_W-1:0] cpl_mem [PAIRS];
  logic signed [ims_pkg::CPL_W-1:0] cpl_q;
  logic                             cpl_wr_en;
  logic [PAW-1:0]                   cpl_rd_addr;

  // field and counter stores
  ims_pkg::fld_ctrl_t        fld_ctrl;
  logic [SW-1:0]             fld_rd_addr;
  logic [SW-1:0]             fld_wr_addr;
  logic signed [FW-1:0]      fld_wr_data;
  logic signed [FW-1:0]      fld_q;
  ims_pkg::cnt_ctrl_t        cnt_ctrl;
  logic [PAW-1:0]            pair_rd_addr;
  logic [PAW-1:0]            pair_wr_addr;
  logic [COUNT_WIDTH-1:0]    pair_wd;
  logic [HAW-1:0]            hist_rd_addr;
  logic [HAW-1:0]            hist_wr_addr;
  logic [COUNT_WIDTH-1:0]    hist_wd;
  logic [COUNT_WIDTH-1:0]    pair_q;
  logic [COUNT_WIDTH-1:0]    hist_q;
  logic [ims_pkg::EXP_W-1:0] exp_q;

  ims_field_store #(.SITES(SITES)) u_fields (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (fld_ctrl),
    .rd_addr (fld_rd_addr),
    .wr_addr (fld_wr_addr),
    .wr_data (fld_wr_data),
    .q       (fld_q)
  );

  ims_count_store #(.SITES(SITES), .COUNT_WIDTH(COUNT_WIDTH)) u_counts (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (cnt_ctrl),
    .pair_rd_addr (pair_rd_addr),
    .pair_wr_addr (pair_wr_addr),
    .pair_wd      (pair_wd),
    .hist_rd_addr (hist_rd_addr),
    .hist_wr_addr (hist_wr_addr),
    .hist_wd      (hist_wd),
    .pair_q       (pair_q),
    .hist_q       (hist_q)
  );

  ims_exp_rom #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp (
    .clk (clk),
    .idx (eidx_r),
    .q   (exp_q)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign k             = addr_r[SW-1:0];
  assign upd_ok        = d_le0_r || (!d_big_r && (rnd_r < exp_q));
  assign rec_cond      = typed_r[i_r] && spins_r[i_r];
  assign dval          = up_nxt ? (FW+1)'(fld_q) : -((FW+1)'(fld_q));
  assign eprod         = (16+EDW)'(dval[15:0]) * (16+EDW)'(EXP_TABLE_DEPTH);
  assign rd_cnt        = sel_hist_r ? hist_q : pair_q;

  always_comb begin
    state_nxt       = state_r;
    spins_nxt       = spins_r;
    typed_nxt       = typed_r;
    last_active_nxt = last_active_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    clr_nxt         = clr_r;
    clr_cmd_nxt     = clr_cmd_r;
    acc_pend_nxt    = acc_pend_r;
    bad_pend_nxt    = bad_pend_r;
    cnt_pend_nxt    = cnt_pend_r;
    up_nxt          = up_r;
    d_le0_nxt       = d_le0_r;
    d_big_nxt       = d_big_r;
    eidx_nxt        = eidx_r;
    act_nxt         = act_r;
    sel_hist_nxt    = sel_hist_r;
    acc_sum_nxt     = acc_sum_r;
    p1_v_nxt        = 1'b0;
    p1_add_nxt      = p1_add_r;
    p1_first_nxt    = p1_first_r;
    p1_last_nxt     = p1_last_r;
    p1_site_nxt     = p1_site_r;
    p2_v_nxt        = 1'b0;
    p2_skip_nxt     = p2_skip_r;
    p2_site_nxt     = p2_site_r;
    p3_v_nxt        = 1'b0;
    p3_addr_nxt     = p3_addr_r;
    out_load        = 1'b0;
    cpl_wr_en       = 1'b0;
    cpl_rd_addr     = tri_addr(i_r, j_r);
    fld_ctrl        = '0;
    fld_rd_addr     = i_r;
    fld_wr_addr     = p1_site_r;
    fld_wr_data     = '0;
    cnt_ctrl        = '0;
    pair_rd_addr    = tri_addr(i_r, j_r);
    pair_wr_addr    = p3_addr_r;
    pair_wd         = bump(pair_q);
    hist_rd_addr    = act_r;
    hist_wr_addr    = act_r;
    hist_wd         = bump(hist_q);

    case (state_r)
      ST_CLEAR: begin
        cnt_ctrl.pair_wr = 1'b1;
        pair_wr_addr     = clr_r;
        pair_wd          = '0;
        clr_nxt          = clr_r + 1'b1;
        if (clr_r == PAW'(PAIRS - 1)) begin
          clr_cmd_nxt = 1'b0;
          state_nxt   = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          acc_pend_nxt = 1'b0;
          bad_pend_nxt = 1'b0;
          cnt_pend_nxt = '0;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        case (cmd_r)
          ims_pkg::CMD_WR_CPL: begin
            if (addr_r < ims_pkg::ADDR_W'(PAIRS)) cpl_wr_en = 1'b1;
            else bad_pend_nxt = 1'b1;
          end
          ims_pkg::CMD_WR_SPIN: begin
            if (addr_r < ims_pkg::ADDR_W'(SITES)) begin
              spins_nxt[k] = sval_r;
              typed_nxt[k] = tflag_r;
            end else begin
              bad_pend_nxt = 1'b1;
            end
          end
          ims_pkg::CMD_INIT: begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_INIT;
          end
          ims_pkg::CMD_UPDATE: begin
            if (addr_r < ims_pkg::ADDR_W'(SITES)) begin
              fld_ctrl.rd = 1'b1;
              fld_rd_addr = k;
              state_nxt   = ST_UPD_D;
            end else begin
              bad_pend_nxt = 1'b1;
            end
          end
          ims_pkg::CMD_RECORD: begin
            i_nxt     = '0;
            j_nxt     = '0;
            act_nxt   = '0;
            state_nxt = ST_REC;
          end
          ims_pkg::CMD_READ: begin
            if (addr_r < ims_pkg::ADDR_W'(PAIRS)) begin
              cnt_ctrl.pair_rd = 1'b1;
              pair_rd_addr     = addr_r[PAW-1:0];
              sel_hist_nxt     = 1'b0;
              state_nxt        = ST_READ;
            end else if (addr_r < ims_pkg::ADDR_W'(PAIRS + SITES + 1)) begin
              cnt_ctrl.hist_rd = 1'b1;
              hist_rd_addr     = HAW'(addr_r - ims_pkg::ADDR_W'(PAIRS));
              sel_hist_nxt     = 1'b1;
              state_nxt        = ST_READ;
            end else begin
              bad_pend_nxt = 1'b1;
            end
          end
          ims_pkg::CMD_CLEAR: begin
            cnt_ctrl.hist_clr = 1'b1;
            last_active_nxt   = '0;
            clr_nxt           = '0;
            clr_cmd_nxt       = 1'b1;
            state_nxt         = ST_CLEAR;
          end
          default: begin
          end
        endcase
      end
      ST_INIT: begin
        p1_v_nxt     = 1'b1;
        p1_add_nxt   = (i_r == j_r) || spins_r[j_r];
        p1_first_nxt = (j_r == '0);
        p1_last_nxt  = (j_r == LAST_SITE);
        p1_site_nxt  = i_r;
        if (j_r == LAST_SITE) begin
          j_nxt = '0;
          if (i_r == LAST_SITE) state_nxt = ST_DRAIN;
          else i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_UPD_D: begin
        up_nxt    = spins_r[k];
        d_le0_nxt = (dval <= 0);
        d_big_nxt = (dval >= (FW+1)'(ims_pkg::D_SPAN));
        eidx_nxt  = EAW'(eprod >> 16);
        state_nxt = ST_UPD_EXP;
      end
      ST_UPD_EXP: begin
        state_nxt = ST_UPD_DEC;
      end
      ST_UPD_DEC: begin
        if (upd_ok) begin
          spins_nxt    = spins_r ^ (SITES'(1) << k);
          acc_pend_nxt = 1'b1;
          i_nxt        = '0;
          state_nxt    = ST_UPD_SWP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_UPD_SWP: begin
        fld_ctrl.rd = 1'b1;
        fld_rd_addr = i_r;
        cpl_rd_addr = tri_addr(k, i_r);
        p2_v_nxt    = 1'b1;
        p2_skip_nxt = (i_r == k);
        p2_site_nxt = i_r;
        if (i_r == LAST_SITE) state_nxt = ST_DRAIN;
        else i_nxt = i_r + 1'b1;
      end
      ST_REC: begin
        if (rec_cond) begin
          cnt_ctrl.pair_rd = 1'b1;
          p3_v_nxt         = (j_r == i_r) || spins_r[j_r];
          p3_addr_nxt      = tri_addr(i_r, j_r);
          if (j_r == i_r) act_nxt = act_r + 1'b1;
        end
        if ((j_r == LAST_SITE) || ((j_r == i_r) && !rec_cond)) begin
          if (i_r == LAST_SITE) begin
            state_nxt = ST_REC_HRD;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_REC_HRD: begin
        cnt_ctrl.hist_rd = 1'b1;
        state_nxt        = ST_REC_HWR;
      end
      ST_REC_HWR: begin
        cnt_ctrl.hist_wr = 1'b1;
        last_active_nxt  = act_r;
        state_nxt        = ST_DONE;
      end
      ST_READ: begin
        cnt_pend_nxt = (rd_cnt > COUNT_WIDTH'(ims_pkg::CNT_OUT_MAX)) ? '1 :
                       ims_pkg::CNT_OUT_W'(rd_cnt);
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // field build: sum one coupling per cycle, write at the end of each row
    if (p1_v_r) begin
      acc_sum_nxt = (p1_first_r ? '0 : acc_sum_r) + (p1_add_r ? (FW+2)'(cpl_q) : '0);
      if (p1_last_r) begin
        fld_ctrl.wr = 1'b1;
        fld_wr_addr = p1_site_r;
        fld_wr_data = ims_pkg::sat_field(acc_sum_nxt);
      end
    end
    // flip sweep: read field i, write it back in the next cycle
    if (p2_v_r && !p2_skip_r) begin
      fld_ctrl.wr = 1'b1;
      fld_wr_addr = p2_site_r;
      fld_wr_data = ims_pkg::sat_field(up_r ? (FW+2)'(fld_q) - (FW+2)'(cpl_q)
                                            : (FW+2)'(fld_q) + (FW+2)'(cpl_q));
    end
    if (p3_v_r) begin
      cnt_ctrl.pair_wr = 1'b1;
      pair_wr_addr     = p3_addr_r;
      pair_wd          = bump(pair_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      clr_cmd_r     <= 1'b0;
      spins_r       <= '0;
      typed_r       <= '0;
      last_active_r <= '0;
      p1_v_r        <= 1'b0;
      p2_v_r        <= 1'b0;
      p3_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      clr_cmd_r     <= clr_cmd_nxt;
      spins_r       <= spins_nxt;
      typed_r       <= typed_nxt;
      last_active_r <= last_active_nxt;
      p1_v_r        <= p1_v_nxt;
      p2_v_r        <= p2_v_nxt;
      p3_v_r        <= p3_v_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_chan.command;
      addr_r  <= in_chan.address;
      cval_r  <= in_chan.coupling_value;
      sval_r  <= in_chan.spin_value;
      tflag_r <= in_chan.typed_flag;
      rnd_r   <= in_chan.random_fraction;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    acc_pend_r   <= acc_pend_nxt;
    bad_pend_r   <= bad_pend_nxt;
    cnt_pend_r   <= cnt_pend_nxt;
    up_r         <= up_nxt;
    d_le0_r      <= d_le0_nxt;
    d_big_r      <= d_big_nxt;
    eidx_r       <= eidx_nxt;
    act_r        <= act_nxt;
    sel_hist_r   <= sel_hist_nxt;
    acc_sum_r    <= acc_sum_nxt;
    p1_add_r     <= p1_add_nxt;
    p1_first_r   <= p1_first_nxt;
    p1_last_r    <= p1_last_nxt;
    p1_site_r    <= p1_site_nxt;
    p2_skip_r    <= p2_skip_nxt;
    p2_site_r    <= p2_site_nxt;
    p3_addr_r    <= p3_addr_nxt;
    if (out_load) begin
      out_acc_r   <= acc_pend_r;
      out_spins_r <= ims_pkg::SPIN_W'(spins_r);
      out_act_r   <= ims_pkg::ACT_W'(last_active_r);
      out_cnt_r   <= cnt_pend_r;
      out_bad_r   <= bad_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cpl_wr_en) cpl_mem[addr_r[PAW-1:0]] <= cval_r;
    cpl_q <= cpl_mem[cpl_rd_addr];
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.accepted     = out_acc_r;
  assign out_chan.spin_word    = out_spins_r;
  assign out_chan.active_count = out_act_r;
  assign out_chan.count_value  = out_cnt_r;
  assign out_chan.bad_address  = out_bad_r;

  a_flip_applied: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD_DEC && upd_ok) |=> (spins_r != $past(spins_r)))
    else $error("accepted flip did not change the spin word");

  a_fld_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (fld_ctrl.wr && fld_ctrl.rd) |-> (fld_wr_addr != fld_rd_addr))
    else $error("field read and write hit the same entry");

  a_pair_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_ctrl.pair_wr && cnt_ctrl.pair_rd) |-> (pair_wr_addr != pair_rd_addr))
    else $error("pair counter read and write hit the same entry");

  a_one_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> (!p2_v_r && !p3_v_r))
    else $error("two sweeps active at once");

endmodule

// File: tb/tb.sv
// Self-checking Ising Metropolis testbench: coupling fill, directed words, then random words.
module tb;

  localparam int NSITE = 64;
  localparam int NPAIR = NSITE * (NSITE + 1) / 2;
  localparam int NHIST = NSITE + 1;
  localparam int NRAND = 1100;
  localparam logic [ims_pkg::CMD_W-1:0] CMD_NONE = 3'd7;
  localparam longint unsigned CNT_LIMIT = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [ims_pkg::CMD_W-1:0]        cmd;
    logic [ims_pkg::ADDR_W-1:0]       addr;
    logic signed [ims_pkg::CPL_W-1:0] cval;
    logic                             sval;
    logic                             tflag;
    logic [ims_pkg::RND_W-1:0]        rnd;
  } word_t;

  typedef struct packed {
    logic                          acc;
    logic [ims_pkg::SPIN_W-1:0]    spins;
    logic [ims_pkg::ACT_W-1:0]     act;
    logic [ims_pkg::CNT_OUT_W-1:0] cnt;
    logic                          bad;
  } outcome_t;

  typedef struct packed {
    word_t                         w;
    logic                          fixed;
    logic                          bad;
    logic [ims_pkg::CNT_OUT_W-1:0] cnt;
  } row_t;

  logic clk;
  logic rst_n;
  ims_in_if  in_chan();
  ims_out_if out_chan();

  ising_metropolis_sampler dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  // sampler state as predicted
  int              cpl [NPAIR];
  int              fld [NSITE];
  logic [63:0]     spin_st;
  logic [63:0]     typed_st;
  longint unsigned pair_cnt [NPAIR];
  longint unsigned hist_cnt [NHIST];
  int              last_act;
  int              exp_lut [256];

  outcome_t due_q[$];
  int errors;
  int n_words, n_flips, n_records, n_inits;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic int tri_index(input int a, input int b);
    return NSITE - 1 + a * (NSITE - 2) - (a * (a - 1)) / 2 + b;
  endfunction

  function automatic int pair_j(input int a, input int b);
    return (a < b) ? cpl[tri_index(a, b)] : cpl[tri_index(b, a)];
  endfunction

  function automatic int clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic int exp_q16(input int i);
    longint unsigned num, whole, frac, term, v, r;
    longint sum;
    num = longint'(i) * 16;
    whole = num / 256;
    frac = ((num % 256) << 32) / 256;
    term = 64'h1_0000_0000;
    sum = longint'(term);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * frac) >> 32) / longint'(k);
      if (k % 2) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    v = longint'(sum);
    for (longint unsigned n = 0; n < whole; n++)
      v = (v * 64'd1580030169 + 64'h8000_0000) >> 32;
    r = (v + 64'd32768) >> 16;
    return (r > 65535) ? 65535 : int'(r);
  endfunction

  function automatic void bump(ref longint unsigned c);
    if (c < CNT_LIMIT) c++;
  endfunction

  function automatic outcome_t sample_step(input word_t w);
    outcome_t o;
    longint h, d;
    int k, act;
    bit up, ok;
    o = '0;
    case (w.cmd)
      ims_pkg::CMD_WR_CPL: if (w.addr < NPAIR) cpl[w.addr] = int'(w.cval); else o.bad = 1'b1;
      ims_pkg::CMD_WR_SPIN: begin
        if (w.addr < NSITE) begin
          spin_st[w.addr] = w.sval;
          typed_st[w.addr] = w.tflag;
        end else o.bad = 1'b1;
      end
      ims_pkg::CMD_INIT: begin
        n_inits++;
        for (int i = 0; i < NSITE; i++) begin
          h = cpl[i];
          for (int j = 0; j < NSITE; j++)
            if (j != i && spin_st[j]) h += pair_j(i, j);
          fld[i] = clamp24(h);
        end
      end
      ims_pkg::CMD_UPDATE: begin
        if (w.addr < NSITE) begin
          k = int'(w.addr);
          up = spin_st[k];
          d = up ? longint'(fld[k]) : -longint'(fld[k]);
          if (d <= 0) ok = 1'b1;
          else if (d >= ims_pkg::D_SPAN) ok = 1'b0;
          else ok = w.rnd < exp_lut[(d * 256) >> 16];
          if (ok) begin
            spin_st[k] = ~spin_st[k];
            for (int i = 0; i < NSITE; i++)
              if (i != k)
                fld[i] = clamp24(up ? longint'(fld[i]) - pair_j(k, i)
                                    : longint'(fld[i]) + pair_j(k, i));
            o.acc = 1'b1;
            n_flips++;
          end
        end else o.bad = 1'b1;
      end
      ims_pkg::CMD_RECORD: begin
        n_records++;
        act = 0;
        for (int i = 0; i < NSITE; i++) begin
          if (typed_st[i] && spin_st[i]) begin
            bump(pair_cnt[i]);
            act++;
            for (int j = i + 1; j < NSITE; j++)
              if (spin_st[j]) bump(pair_cnt[tri_index(i, j)]);
          end
        end
        bump(hist_cnt[act]);
        last_act = act;
      end
      ims_pkg::CMD_READ: begin
        if (w.addr < NPAIR) o.cnt = pair_cnt[w.addr][31:0];
        else if (w.addr < NPAIR + NHIST) o.cnt = hist_cnt[w.addr - NPAIR][31:0];
        else o.bad = 1'b1;
      end
      ims_pkg::CMD_CLEAR: begin
        foreach (pair_cnt[i]) pair_cnt[i] = 0;
        foreach (hist_cnt[i]) hist_cnt[i] = 0;
        last_act = 0;
      end
      default: ;
    endcase
    o.spins = spin_st;
    o.act = last_act[ims_pkg::ACT_W-1:0];
    return o;
  endfunction

  function automatic int gap_len();
    if (calm || $urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input word_t w, input logic fixed, input logic bad,
                      input logic [ims_pkg::CNT_OUT_W-1:0] cnt);
    outcome_t o;
    int g;
    in_chan.valid <= 1'b1;
    in_chan.command <= w.cmd;
    in_chan.address <= w.addr;
    in_chan.coupling_value <= w.cval;
    in_chan.spin_value <= w.sval;
    in_chan.typed_flag <= w.tflag;
    in_chan.random_fraction <= w.rnd;
    do @(posedge clk); while (!in_chan.ready);
    o = sample_step(w);
    if (fixed) begin
      o.bad = bad;
      o.cnt = cnt;
    end
    due_q.push_back(o);
    n_words++;
    g = gap_len();
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [ims_pkg::CPL_W-1:0] rand_coupling();
    if ($urandom_range(0, 9) == 0) return ims_pkg::CPL_W'($urandom);
    return ims_pkg::CPL_W'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic logic [ims_pkg::ADDR_W-1:0] rand_addr(input int top);
    if ($urandom_range(0, 29) == 0) return ims_pkg::ADDR_W'($urandom_range(top, 4095));
    return ims_pkg::ADDR_W'($urandom_range(0, top - 1));
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int p;
    w.cval = ims_pkg::CPL_W'($urandom);
    w.sval = 1'($urandom_range(0, 1));
    w.tflag = 1'($urandom_range(0, 1));
    w.rnd = ims_pkg::RND_W'($urandom);
    p = $urandom_range(0, 99);
    if (p < 50) begin
      w.cmd = ims_pkg::CMD_UPDATE;
      w.addr = rand_addr(NSITE);
    end else if (p < 65) begin
      w.cmd = ims_pkg::CMD_WR_SPIN;
      w.addr = rand_addr(NSITE);
    end else if (p < 75) begin
      w.cmd = ims_pkg::CMD_WR_CPL;
      w.addr = rand_addr(NPAIR);
      w.cval = rand_coupling();
    end else if (p < 78) begin
      w.cmd = ims_pkg::CMD_INIT;
      w.addr = ims_pkg::ADDR_W'($urandom);
    end else if (p < 86) begin
      w.cmd = ims_pkg::CMD_RECORD;
      w.addr = ims_pkg::ADDR_W'($urandom);
    end else if (p < 96) begin
      w.cmd = ims_pkg::CMD_READ;
      w.addr = rand_addr(NPAIR + NHIST);
    end else if (p < 98) begin
      w.cmd = ims_pkg::CMD_CLEAR;
      w.addr = ims_pkg::ADDR_W'($urandom);
    end else begin
      w.cmd = CMD_NONE;
      w.addr = ims_pkg::ADDR_W'($urandom);
    end
    return w;
  endfunction

  // result side: random back-pressure
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0)
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_q.size() == 0) report("unexpected word", out_chan.spin_word, 0);
      else begin
        e = due_q.pop_front();
        if (out_chan.accepted !== e.acc) report("accepted", out_chan.accepted, e.acc);
        if (out_chan.spin_word !== e.spins) report("spin_word", out_chan.spin_word, e.spins);
        if (out_chan.active_count !== e.act) report("active_count", out_chan.active_count, e.act);
        if (out_chan.count_value !== e.cnt) report("count_value", out_chan.count_value, e.cnt);
        if (out_chan.bad_address !== e.bad) report("bad_address", out_chan.bad_address, e.bad);
      end
    end
  end

  row_t dir_rows [] = '{
    '{'{ims_pkg::CMD_READ,    12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b1, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_READ,    12'd2144, 16'sd0,   1'b0, 1'b0, 16'd0},     1'b1, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_READ,    12'd2145, 16'sd0,   1'b0, 1'b0, 16'd0},     1'b1, 1'b1, 32'd0},
    '{'{ims_pkg::CMD_WR_CPL,  12'd2080, 16'sd5,   1'b0, 1'b0, 16'd0},     1'b1, 1'b1, 32'd0},
    '{'{ims_pkg::CMD_WR_CPL,  12'd4095, -16'sd1,  1'b1, 1'b1, 16'hFFFF}, 1'b1, 1'b1, 32'd0},
    '{'{ims_pkg::CMD_WR_CPL,  12'd0,    16'sh7FFF, 1'b0, 1'b0, 16'd0},   1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_WR_CPL,  12'd2079, 16'sh8000, 1'b0, 1'b0, 16'd0},   1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_WR_SPIN, 12'd64,   16'sd0,   1'b1, 1'b1, 16'd0},     1'b1, 1'b1, 32'd0},
    '{'{ims_pkg::CMD_WR_SPIN, 12'd0,    16'sd0,   1'b1, 1'b1, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_WR_SPIN, 12'd63,   16'sd0,   1'b1, 1'b1, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_WR_SPIN, 12'd5,    16'sd0,   1'b1, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_INIT,    12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_UPDATE,  12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_UPDATE,  12'd63,   16'sd0,   1'b0, 1'b0, 16'hFFFF}, 1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_UPDATE,  12'd64,   16'sd0,   1'b0, 1'b0, 16'd0},     1'b1, 1'b1, 32'd0},
    '{'{ims_pkg::CMD_RECORD,  12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_READ,    12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_READ,    12'd126,  16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_READ,    12'd2082, 16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{CMD_NONE,             12'd4095, -16'sd1,  1'b1, 1'b1, 16'hFFFF}, 1'b1, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_CLEAR,   12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_READ,    12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b1, 1'b0, 32'd0},
    '{'{ims_pkg::CMD_RECORD,  12'd0,    16'sd0,   1'b0, 1'b0, 16'd0},     1'b0, 1'b0, 32'd0}
  };

  initial begin
    word_t w;
    int spin_total;
    errors = 0;
    n_words = 0;
    n_flips = 0;
    n_records = 0;
    n_inits = 0;
    calm = 1'b0;
    spin_st = '0;
    typed_st = '0;
    last_act = 0;
    foreach (cpl[i]) cpl[i] = 0;
    foreach (fld[i]) fld[i] = 0;
    foreach (pair_cnt[i]) pair_cnt[i] = 0;
    foreach (hist_cnt[i]) hist_cnt[i] = 0;
    foreach (exp_lut[i]) exp_lut[i] = exp_q16(i);
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.command <= CMD_NONE;
    in_chan.address <= '0;
    in_chan.coupling_value <= '0;
    in_chan.spin_value <= 1'b0;
    in_chan.typed_flag <= 1'b0;
    in_chan.random_fraction <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every coupling word is written before anything reads the store
    for (int a = 0; a < NPAIR; a++) begin
      w = '0;
      w.cmd = ims_pkg::CMD_WR_CPL;
      w.addr = ims_pkg::ADDR_W'(a);
      w.cval = rand_coupling();
      send(w, 1'b0, 1'b0, '0);
    end

    foreach (dir_rows[r]) send(dir_rows[r].w, dir_rows[r].fixed, dir_rows[r].bad, dir_rows[r].cnt);

    // every spin high and typed, then a field build, the widest record and its histogram bin read
    for (int s = 0; s < NSITE; s++) begin
      w = '0;
      w.cmd = ims_pkg::CMD_WR_SPIN;
      w.addr = ims_pkg::ADDR_W'(s);
      w.sval = 1'b1;
      w.tflag = 1'b1;
      send(w, 1'b0, 1'b0, '0);
    end
    w = '0;
    w.cmd = ims_pkg::CMD_INIT;
    send(w, 1'b0, 1'b0, '0);
    w.cmd = ims_pkg::CMD_RECORD;
    send(w, 1'b0, 1'b0, '0);
    w.cmd = ims_pkg::CMD_READ;
    w.addr = ims_pkg::ADDR_W'(NPAIR + NSITE);
    send(w, 1'b1, 1'b0, 32'd1);

    for (int n = 0; n < NRAND; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send(rand_word(), 1'b0, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
    spin_total = $countones(spin_st);
    $display("Ran %0d words: %0d flips accepted, %0d field builds, %0d records.",
             n_words, n_flips, n_inits, n_records);
    $display("Final spin count %0d, %0d mismatches.", spin_total, errors);
    if (errors == 0 && due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
